// File: hdl/lcms_pkg.sv
// ----------------------------------------------------------------------------
// Leader clustering margin search package
// Shared widths, register indexes and payload types.
// ----------------------------------------------------------------------------
package lcms_pkg;
    localparam int MAX_ITEMS  = 64;
    localparam int VALUE_BITS = 16;
    localparam int IDX_BITS   = $clog2(MAX_ITEMS);
    localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);
    localparam int SUM_BITS   = VALUE_BITS + IDX_BITS;

    localparam logic [1:0] REG_TARGET_GROUPS  = 2'd0;
    localparam logic [1:0] REG_DEVIATION_STEP = 2'd1;
    localparam logic [1:0] REG_MAX_PASSES     = 2'd2;

    typedef struct packed {
        logic [15:0] sample_value;
        logic        is_last;
    } in_item_t;

    typedef struct packed {
        logic [15:0] member_value;
        logic [5:0]  group_index;
        logic        converged;
        logic        end_of_run;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [15:0] data;
    } cfg_item_t;
endpackage

// File: hdl/lcms_stream_if.sv
// ----------------------------------------------------------------------------
// Leader clustering margin search channels
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface lcms_in_if;
    logic                valid;
    logic                ready;
    lcms_pkg::in_item_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lcms_out_if;
    logic                valid;
    logic                ready;
    lcms_pkg::out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lcms_cfg_if;
    logic                valid;
    logic                ready;
    lcms_pkg::cfg_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/leader_clustering_margin_search_unit.sv
// ----------------------------------------------------------------------------
// Leader clustering margin search unit
// Operation: loads the set beat by beat, sorts it by insertion, divides for the
// starting margin, then runs search passes that test each value against the open
// groups, then emits n output beats, one per unstalled cycle.
// Throughput: one set at a time; not ready while a set is searched or emitted.
// Asynchronous active-low reset restores register defaults and clears counts.
// ----------------------------------------------------------------------------
module leader_clustering_margin_search_unit (
    input  logic clk,
    input  logic rst_n,
    lcms_in_if.sink    in_ch,
    lcms_out_if.source out_ch,
    lcms_cfg_if.sink   cfg
);
    import lcms_pkg::*;

    typedef enum logic [11:0] {
        ST_LOAD  = 12'b000000000001,
        ST_SORTR = 12'b000000000010,
        ST_SORTC = 12'b000000000100,
        ST_DSET  = 12'b000000001000,
        ST_DIV   = 12'b000000010000,
        ST_PLOAD = 12'b000000100000,
        ST_PITEM = 12'b000001000000,
        ST_PRD   = 12'b000010000000,
        ST_PMUL  = 12'b000100000000,
        ST_PCMP  = 12'b001000000000,
        ST_PEND  = 12'b010000000000,
        ST_OUT   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic [6:0]  target_reg;
    logic [15:0] step_reg;
    logic [9:0]  maxp_reg;

    logic [VALUE_BITS-1:0] vals [MAX_ITEMS];
    logic [SUM_BITS-1:0]   gsum [MAX_ITEMS];
    logic [CNT_BITS-1:0]   gsize [MAX_ITEMS];
    logic [IDX_BITS-1:0]   gof [MAX_ITEMS];

    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] i_reg, j_reg;
    logic [CNT_BITS-1:0] g_reg, gtot_reg;
    logic [9:0]          pass_reg;
    logic signed [31:0]  dev_reg;
    logic                conv_reg;
    logic [VALUE_BITS-1:0] key_reg, prev_reg, rdv_reg, mv_reg;
    logic [IDX_BITS-1:0]   gi_reg;
    logic [SUM_BITS-1:0] rsum_reg;
    logic [CNT_BITS-1:0] rsize_reg;
    // Divider: restoring, one quotient bit per cycle.
    logic [VALUE_BITS+8:0] rem_reg, quo_reg;
    logic [4:0]            dcnt_reg;
    // Registered products of the margin test.
    logic signed [SUM_BITS+1:0] diff_reg;
    logic signed [47:0]         rhs_reg;

    logic [6:0] tgt_eff;
    logic [9:0] lim_eff;
    assign tgt_eff = (target_reg == 7'd0) ? 7'd1 : target_reg;
    assign lim_eff = (maxp_reg == 10'd0) ? 10'd1 : maxp_reg;

    logic in_acc, out_acc;
    assign in_ch.ready = (state_reg == ST_LOAD);
    assign in_acc = in_ch.valid && in_ch.ready;
    assign cfg.ready = 1'b1;
    assign out_ch.valid = (state_reg == ST_OUT);
    assign out_acc = out_ch.valid && out_ch.ready;

    logic [IDX_BITS-1:0] i_idx, j_idx, g_idx, nxt_idx, jm2_idx, rda_idx, rdb_idx;
    assign i_idx   = i_reg[IDX_BITS-1:0];
    assign j_idx   = j_reg[IDX_BITS-1:0];
    assign g_idx   = g_reg[IDX_BITS-1:0];
    assign nxt_idx = i_idx + 1'b1;
    assign jm2_idx = j_idx - 2'd2;

    logic sort_done, sort_shift, conv_hit, bound_hit;
    assign sort_done  = (i_reg >= count_reg);
    assign sort_shift = (j_reg != '0) && (prev_reg < key_reg);
    assign conv_hit   = (gtot_reg == CNT_BITS'(tgt_eff));
    assign bound_hit  = (pass_reg + 1'b1 >= lim_eff);

    // Once the sort is done the two read ports fetch the largest and smallest.
    assign rda_idx = sort_done ? '0 : i_idx;
    assign rdb_idx = sort_done ? IDX_BITS'(count_reg - 1'b1) : i_idx - 1'b1;

    assign out_ch.payload.member_value = mv_reg;
    assign out_ch.payload.group_index  = gi_reg;
    assign out_ch.payload.converged    = conv_reg;
    assign out_ch.payload.end_of_run   = (i_reg + 1'b1 == count_reg);

    logic signed [SUM_BITS+1:0] d_raw;
    logic [SUM_BITS+1:0]        d_abs;
    logic signed [32:0]         div_try;
    logic signed [33:0]         dev_sum;
    logic signed [31:0]         dev_sat;
    logic                       fits;

    always_comb
    begin
        d_raw = $signed({2'b00, rsum_reg})
              - $signed({2'b00, rdv_reg} * {{(SUM_BITS+2-CNT_BITS){1'b0}}, rsize_reg});
        d_abs = d_raw[SUM_BITS+1] ? -d_raw : d_raw;
        div_try = $signed({1'b0, rem_reg[VALUE_BITS+7:0], quo_reg[VALUE_BITS+8]})
                - $signed({26'd0, tgt_eff});
        if (gtot_reg < CNT_BITS'(tgt_eff))
            dev_sum = {{2{dev_reg[31]}}, dev_reg} - $signed({18'd0, step_reg});
        else
            dev_sum = {{2{dev_reg[31]}}, dev_reg} + $signed({18'd0, step_reg});
        if (dev_sum > 34'sd2147483647)
            dev_sat = 32'sh7fffffff;
        else if (dev_sum < -34'sd2147483648)
            dev_sat = 32'sh80000000;
        else
            dev_sat = dev_sum[31:0];
        fits = ($signed({diff_reg, 9'd0}) < rhs_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:  if (in_acc && in_ch.payload.is_last) state_next = ST_SORTR;
            ST_SORTR: state_next = sort_done ? ST_DSET : ST_SORTC;
            ST_SORTC: state_next = sort_shift ? ST_SORTC : ST_SORTR;
            ST_DSET:  state_next = ST_DIV;
            ST_DIV:   if (dcnt_reg == 5'd0) state_next = ST_PLOAD;
            ST_PLOAD: state_next = ST_PITEM;
            ST_PITEM:
            begin
                if (i_reg >= count_reg)
                    state_next = ST_PEND;
                else if (g_reg < gtot_reg)
                    state_next = ST_PRD;
                else
                    state_next = ST_PLOAD;
            end
            ST_PRD:   state_next = ST_PMUL;
            ST_PMUL:  state_next = ST_PCMP;
            ST_PCMP:  state_next = fits ? ST_PLOAD : ST_PITEM;
            ST_PEND:  state_next = (conv_hit || bound_hit) ? ST_OUT : ST_PLOAD;
            ST_OUT:   if (out_acc && out_ch.payload.end_of_run) state_next = ST_LOAD;
            default:  state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= 7'd4;
            step_reg   <= 16'd256;
            maxp_reg   <= 10'd256;
        end
        else if (cfg.valid)
        begin
            case (cfg.payload.index)
                REG_TARGET_GROUPS:  target_reg <= cfg.payload.data[6:0];
                REG_DEVIATION_STEP: step_reg   <= cfg.payload.data;
                REG_MAX_PASSES:     maxp_reg   <= cfg.payload.data[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD && in_acc && count_reg < CNT_BITS'(MAX_ITEMS))
            vals[count_reg[IDX_BITS-1:0]] <= in_ch.payload.sample_value[VALUE_BITS-1:0];
        else if (state_reg == ST_SORTC)
            vals[j_idx] <= sort_shift ? prev_reg : key_reg;
        if (state_reg == ST_SORTR)
        begin
            key_reg  <= vals[rda_idx];
            prev_reg <= vals[rdb_idx];
        end
        else if (state_reg == ST_SORTC && sort_shift)
            prev_reg <= vals[jm2_idx];
        if (state_reg == ST_PLOAD)
            rdv_reg <= vals[i_idx];
        // The first output beat is fetched at the end of the last pass.
        if (state_reg == ST_PEND)
        begin
            mv_reg <= vals[0];
            gi_reg <= gof[0];
        end
        else if (out_acc)
        begin
            mv_reg <= vals[nxt_idx];
            gi_reg <= gof[nxt_idx];
        end
        if (state_reg == ST_PRD)
        begin
            rsum_reg  <= gsum[g_idx];
            rsize_reg <= gsize[g_idx];
        end
        if (state_reg == ST_PMUL)
        begin
            diff_reg <= $signed(d_abs);
            rhs_reg  <= dev_reg * $signed({9'd0, rsize_reg});
        end
        if (state_reg == ST_PCMP && fits)
        begin
            gsum[g_idx]  <= rsum_reg + SUM_BITS'(rdv_reg);
            gsize[g_idx] <= rsize_reg + 1'b1;
            gof[i_idx]   <= g_idx;
        end
        else if (state_reg == ST_PITEM && i_reg < count_reg && g_reg == gtot_reg
                 && gtot_reg < CNT_BITS'(MAX_ITEMS))
        begin
            gsum[g_idx]  <= SUM_BITS'(rdv_reg);
            gsize[g_idx] <= CNT_BITS'(1);
            gof[i_idx]   <= g_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            g_reg     <= '0;
            gtot_reg  <= '0;
            pass_reg  <= '0;
            dev_reg   <= '0;
            conv_reg  <= 1'b0;
            rem_reg   <= '0;
            quo_reg   <= '0;
            dcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (count_reg < CNT_BITS'(MAX_ITEMS))
                            count_reg <= count_reg + 1'b1;
                        i_reg <= CNT_BITS'(1);
                        j_reg <= CNT_BITS'(1);
                    end
                end
                ST_SORTR:
                begin
                    j_reg <= i_reg;
                end
                ST_SORTC:
                begin
                    if (sort_shift)
                        j_reg <= j_reg - 1'b1;
                    else
                        i_reg <= i_reg + 1'b1;
                end
                ST_DSET:
                begin
                    // Start the (max+min)*256/target divide.
                    rem_reg  <= '0;
                    quo_reg  <= {({1'b0, key_reg} + {1'b0, prev_reg}), 8'd0};
                    dcnt_reg <= 5'(VALUE_BITS + 9);
                end
                ST_DIV:
                begin
                    if (dcnt_reg != 5'd0)
                    begin
                        dcnt_reg <= dcnt_reg - 1'b1;
                        if (!div_try[32])
                        begin
                            rem_reg <= div_try[VALUE_BITS+8:0];
                            quo_reg <= {quo_reg[VALUE_BITS+7:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[VALUE_BITS+7:0], quo_reg[VALUE_BITS+8]};
                            quo_reg <= {quo_reg[VALUE_BITS+7:0], 1'b0};
                        end
                    end
                    else
                    begin
                        dev_reg  <= $signed({7'd0, quo_reg});
                        pass_reg <= '0;
                        i_reg    <= '0;
                        g_reg    <= '0;
                        gtot_reg <= '0;
                    end
                end
                ST_PITEM:
                begin
                    if (i_reg < count_reg && g_reg >= gtot_reg)
                    begin
                        if (gtot_reg < CNT_BITS'(MAX_ITEMS))
                            gtot_reg <= gtot_reg + 1'b1;
                        i_reg <= i_reg + 1'b1;
                        g_reg <= '0;
                    end
                end
                ST_PCMP:
                begin
                    if (fits)
                    begin
                        i_reg <= i_reg + 1'b1;
                        g_reg <= '0;
                    end
                    else
                        g_reg <= g_reg + 1'b1;
                end
                ST_PEND:
                begin
                    i_reg <= '0;
                    g_reg <= '0;
                    if (conv_hit)
                        conv_reg <= 1'b1;
                    else if (bound_hit)
                        conv_reg <= 1'b0;
                    else
                    begin
                        dev_reg  <= dev_sat;
                        gtot_reg <= '0;
                    end
                    pass_reg <= pass_reg + 1'b1;
                end
                ST_OUT:
                begin
                    if (out_acc)
                    begin
                        i_reg <= i_reg + 1'b1;
                        if (out_ch.payload.end_of_run)
                            count_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (i_reg < count_reg))
        else $error("output beat beyond stored set");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PCMP) |-> (g_reg < gtot_reg))
        else $error("compare against unopened group");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> (count_reg != '0))
        else $error("search running on empty set");
endmodule

// File: tb/sv/leader_clustering_margin_search_unit_tb.sv
// ----------------------------------------------------------------------------
// Leader clustering margin search unit testbench
// Loads sets of values, predicts the sorted members with their groups and the
// converged flag, and checks every output beat field by field. Register
// settings change between phases. Input idling and output stalls vary by phase.
// ----------------------------------------------------------------------------
module leader_clustering_margin_search_unit_tb;
    import lcms_pkg::*;

    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 40;

    logic clk;
    logic rst_n;

    lcms_in_if  in_ch();
    lcms_out_if out_ch();
    lcms_cfg_if cfg();

    leader_clustering_margin_search_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    // Register copies and search state of the predictor
    int unsigned target_reg;
    int unsigned step_reg;
    int unsigned passes_reg;
    logic [15:0] set_values [MAX_ITEMS];
    int unsigned set_count;
    longint      grp_sum [MAX_ITEMS];
    int unsigned grp_size [MAX_ITEMS];
    int unsigned member_grp [MAX_ITEMS];
    longint      deviation;
    int unsigned grp_total;

    in_item_t  pending_samples[$];
    out_item_t expected_members[$];

    int unsigned idle_mode;
    int unsigned mismatches;
    int unsigned cycles;

    always #5 clk = ~clk;

    function automatic longint clamp_deviation(longint d);
        if (d > 64'sd2147483647)
            return 64'sd2147483647;
        if (d < -64'sd2147483648)
            return -64'sd2147483648;
        return d;
    endfunction

    function automatic void run_cluster_pass(int unsigned n);
        longint v;
        longint diff;
        bit placed;
        grp_total = 0;
        for (int i = 0; i < n; i++)
        begin
            v = set_values[i];
            placed = 0;
            for (int g = 0; g < grp_total; g++)
            begin
                diff = grp_sum[g] - v * longint'(grp_size[g]);
                if (diff < 0)
                    diff = -diff;
                if (diff * 512 < deviation * longint'(grp_size[g]))
                begin
                    grp_sum[g] += v;
                    grp_size[g] += 1;
                    member_grp[i] = g;
                    placed = 1;
                    break;
                end
            end
            if (!placed && grp_total < MAX_ITEMS)
            begin
                grp_sum[grp_total] = v;
                grp_size[grp_total] = 1;
                member_grp[i] = grp_total;
                grp_total++;
            end
        end
    endfunction

    function automatic void cluster_sample(in_item_t it);
        int unsigned n;
        int unsigned tgt;
        int unsigned limit;
        int unsigned passes;
        int j;
        logic [15:0] v;
        bit conv;
        out_item_t r;
        if (set_count < MAX_ITEMS)
        begin
            set_values[set_count] = it.sample_value;
            set_count++;
        end
        if (!it.is_last)
            return;
        n = set_count;
        // Descending insertion sort
        for (int i = 1; i < n; i++)
        begin
            v = set_values[i];
            j = i;
            while (j > 0 && set_values[j - 1] < v)
            begin
                set_values[j] = set_values[j - 1];
                j--;
            end
            set_values[j] = v;
        end
        tgt = (target_reg == 0) ? 1 : target_reg;
        limit = (passes_reg == 0) ? 1 : passes_reg;
        deviation = clamp_deviation(
            ((longint'(set_values[0]) + longint'(set_values[n - 1])) << 8) / tgt);
        passes = 0;
        conv = 0;
        forever
        begin
            run_cluster_pass(n);
            passes++;
            if (grp_total == tgt)
            begin
                conv = 1;
                break;
            end
            if (passes >= limit)
                break;
            if (grp_total < tgt)
                deviation = clamp_deviation(deviation - step_reg);
            else
                deviation = clamp_deviation(deviation + step_reg);
        end
        for (int i = 0; i < n; i++)
        begin
            r.member_value = set_values[i];
            r.group_index  = member_grp[i][5:0];
            r.converged    = conv;
            r.end_of_run   = (i + 1 == n);
            expected_members.insert(expected_members.size(), r);
        end
        set_count = 0;
    endfunction

    // Input driver
    always @(posedge clk)
    begin
        bit busy;
        busy = in_ch.valid;
        if (in_ch.valid && in_ch.ready)
        begin
            cluster_sample(pending_samples.pop_front());
            busy = 0;
        end
        if (!busy)
        begin
            if (pending_samples.size() > 0 &&
                !((idle_mode == 1 && $urandom_range(99) < 83) ||
                  (idle_mode == 3 && $urandom_range(99) < 18)))
            begin
                in_ch.valid   <= 1'b1;
                in_ch.payload <= pending_samples[0];
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Output monitor
    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (out_ch.valid && out_ch.ready)
        begin
            got = out_ch.payload;
            if (expected_members.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected member beat: value %0d group %0d",
                             got.member_value, got.group_index);
            end
            else
            begin
                want = expected_members.pop_front();
                if (got.member_value != want.member_value ||
                    got.group_index != want.group_index ||
                    got.converged != want.converged ||
                    got.end_of_run != want.end_of_run)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"member mismatch: expected v=%0d g=%0d c=%0b e=%0b, ",
                                  "got v=%0d g=%0d c=%0b e=%0b"},
                                 want.member_value, want.group_index, want.converged,
                                 want.end_of_run, got.member_value, got.group_index,
                                 got.converged, got.end_of_run);
                end
            end
        end
        out_ch.ready <= !((idle_mode == 2 && $urandom_range(99) < 83) ||
                          (idle_mode == 3 && $urandom_range(99) < 18));
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_register(logic [1:0] index, logic [15:0] data);
        cfg.valid         <= 1'b1;
        cfg.payload.index <= index;
        cfg.payload.data  <= data;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        case (index)
            REG_TARGET_GROUPS:  target_reg = data & 16'h7F;
            REG_DEVIATION_STEP: step_reg   = data;
            REG_MAX_PASSES:     passes_reg = data & 16'h3FF;
            default: ;
        endcase
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_registers(int unsigned tgt, int unsigned stp, int unsigned pas);
        write_register(REG_TARGET_GROUPS, 16'(tgt));
        write_register(REG_DEVIATION_STEP, 16'(stp));
        write_register(REG_MAX_PASSES, 16'(pas));
    endtask

    task automatic drain_block();
        @(posedge clk);
        while (pending_samples.size() > 0 || expected_members.size() > 0 || in_ch.valid)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_sample(logic [15:0] v, logic last);
        in_item_t it;
        it.sample_value = v;
        it.is_last      = last;
        pending_samples.insert(pending_samples.size(), it);
    endtask

    // Random set: values either spread over the full range or clustered
    // around a few centres so that groups actually merge.
    task automatic queue_random_set(int unsigned n);
        logic [15:0] centre;
        bit spread;
        spread = $urandom_range(2) == 0;
        centre = 16'($urandom);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(3) == 0)
                centre = 16'($urandom);
            queue_sample(spread ? 16'($urandom) : 16'(centre + $urandom_range(400)),
                         i == n - 1);
        end
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        in_ch.valid = 0;
        in_ch.payload = '0;
        out_ch.ready = 0;
        cfg.valid = 0;
        cfg.payload = '0;
        idle_mode = 0;
        mismatches = 0;
        cycles = 0;
        target_reg = 4;
        step_reg = 256;
        passes_reg = 256;
        set_count = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: single values at both extremes, ties, wide spread
        queue_sample(16'd0, 1'b1);
        queue_sample(16'hFFFF, 1'b1);
        queue_sample(16'd5, 1'b0);
        queue_sample(16'd5, 1'b0);
        queue_sample(16'd5, 1'b1);
        queue_sample(16'hFFFF, 1'b0);
        queue_sample(16'd0, 1'b0);
        queue_sample(16'd30000, 1'b0);
        queue_sample(16'd31000, 1'b1);
        drain_block();

        // Single target, no step, longest pass bound
        set_registers(1, 0, 1023);
        write_register(REG_SPARE, 16'hFFFF);
        queue_sample(16'd100, 1'b0);
        queue_sample(16'd60000, 1'b0);
        queue_sample(16'd101, 1'b1);
        drain_block();

        // Zero target and zero pass bound, largest step
        idle_mode = 1;
        set_registers(0, 65535, 0);
        queue_sample(16'd1000, 1'b0);
        queue_sample(16'd40000, 1'b1);
        drain_block();

        // Target out of reach: runs to the pass bound unconverged
        idle_mode = 2;
        set_registers(127, 1, 1023);
        queue_sample(16'd7, 1'b0);
        queue_sample(16'd9000, 1'b1);
        drain_block();

        // Full buffer: the last two values are dropped, the flag still starts
        idle_mode = 3;
        set_registers(64, 4096, 3);
        for (int i = 0; i < MAX_ITEMS + 2; i++)
            queue_sample(16'($urandom), i == MAX_ITEMS + 1);
        drain_block();

        for (int ph = 0; ph < 4; ph++)
        begin
            int unsigned total;
            idle_mode = ph % 4;
            set_registers($urandom_range(1, 8), $urandom_range(3) == 0 ?
                          16'($urandom) : $urandom_range(1, 2000), $urandom_range(1, 40));
            total = 0;
            while (total < 8)
            begin
                int unsigned n;
                n = $urandom_range(1, 10);
                queue_random_set(n);
                total += n;
            end
            drain_block();
        end

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// File: leader_clustering_margin_search_unit.f
hdl/lcms_pkg.sv
hdl/lcms_stream_if.sv
hdl/leader_clustering_margin_search_unit.sv
tb/sv/leader_clustering_margin_search_unit_tb.sv
